### hw/rtl/text_console_scrollback_buffer_assert.svh
// Assertion macros used by the checker file of the scrollback buffer.
`ifndef TEXT_CONSOLE_SCROLLBACK_BUFFER_ASSERT_SVH
`define TEXT_CONSOLE_SCROLLBACK_BUFFER_ASSERT_SVH

// A property checked at each rising clock edge while reset is released.
`define TCSB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A signal that holds while its channel is stalled.
`define TCSB_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (vld && !rdy) |=> $stable(sig)) \
    else $error(msg);

`endif

### hw/rtl/tcsb_pkg.sv
// Constants, character codes and controller/datapath structs of the scrollback buffer.
package tcsb_pkg;

  localparam int LINES      = 128;
  localparam int LINE_WIDTH = 64;
  localparam int TAB_SPACES = 4;

  localparam int SLOT_W     = $clog2(LINES);
  localparam int HELD_W     = $clog2(LINES + 1);
  localparam int COL_W      = $clog2(LINE_WIDTH + 1);
  localparam int ADDR_W     = $clog2(LINES * LINE_WIDTH);
  localparam int CNT_W      = $clog2(TAB_SPACES + 1);

  localparam int CHAR_W     = 8;
  localparam int LINE_IDX_W = 7;
  localparam int COLUMN_W   = 6;
  localparam int LH_W       = 8;
  localparam int CC_W       = 7;

  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SUBST   = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'd126;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic capture;
    logic put;
    logic open_line;
    logic rd_issue;
    logic load_out;
  } tcsb_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_cr;
    logic is_lf;
    logic is_tab;
    logic out_full;
  } tcsb_sts_t;

endpackage

### hw/rtl/tcsb_req_if.sv
// Request channel: valid/ready handshake with the append or read request payload.
interface tcsb_req_if
  import tcsb_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [CHAR_W-1:0]     char_code;
  logic [LINE_IDX_W-1:0] line_index;
  logic [COLUMN_W-1:0]   column;

  modport source (output valid, req_type, char_code, line_index, column, input ready);
  modport sink   (input valid, req_type, char_code, line_index, column, output ready);
endinterface

### hw/rtl/tcsb_rsp_if.sv
// Response channel: valid/ready handshake with the read character and status payload.
interface tcsb_rsp_if
  import tcsb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] read_char;
  logic [LH_W-1:0]   lines_held;
  logic [CC_W-1:0]   cursor_column;

  modport source (output valid, read_char, lines_held, cursor_column, input ready);
  modport sink   (input valid, read_char, lines_held, cursor_column, output ready);
endinterface

### hw/rtl/tcsb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tcsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tcsb_ctrl.sv
// Controller state machine that sequences append, line open and read operations.
module tcsb_ctrl
  import tcsb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tcsb_sts_t sts_i,
  output tcsb_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUT  = 3'd1;
  localparam logic [2:0] S_OPEN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.is_read) begin
            state_d = S_RD;
          end else if (sts_i.is_cr) begin
            state_d = S_DONE;
          end else if (sts_i.is_lf) begin
            state_d = S_OPEN;
          end else begin
            state_d = S_PUT;
            cnt_d   = sts_i.is_tab ? CNT_W'(TAB_SPACES) : CNT_W'(1);
          end
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        cnt_d     = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_DONE;
        end
      end
      S_OPEN: begin
        cmd_o.open_line = 1'b1;
        state_d         = S_DONE;
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hw/rtl/tcsb_dp.sv
// Datapath: ring pointers, line length store, character store and output register.
module tcsb_dp
  import tcsb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcsb_cmd_t             cmd_i,
  output tcsb_sts_t             sts_o,
  input  logic                  req_type_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic [LINE_IDX_W-1:0] line_index_i,
  input  logic [COLUMN_W-1:0]   column_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [CHAR_W-1:0]     read_char_o,
  output logic [LH_W-1:0]       lines_held_o,
  output logic [CC_W-1:0]       cursor_column_o
);

  logic [SLOT_W-1:0]     oldest_q, oldest_d, oldest_n;
  logic [HELD_W-1:0]     held_q, held_d, held_n;
  logic [COL_W-1:0]      col_q, col_d, col_base;
  logic [LINES-1:0]      len_vld_q, len_vld_d;
  logic                  out_valid_q;

  logic                  is_read_q;
  logic [CHAR_W-1:0]     char_q;
  logic [LINE_IDX_W-1:0] line_q;
  logic [COLUMN_W-1:0]   rcol_q;
  logic                  hit_q, vld_q;
  logic [CHAR_W-1:0]     read_char_q;
  logic [LH_W-1:0]       lines_held_q;
  logic [CC_W-1:0]       cursor_q;

  logic                  printable;
  logic [CHAR_W-1:0]     put_char;
  logic                  do_open;
  logic [HELD_W:0]       nsum, rsum;
  logic [SLOT_W-1:0]     new_slot, rd_slot;
  logic                  rd_hit;
  logic                  len_we;
  logic [COL_W-1:0]      len_wdata, len_rdata;
  logic [ADDR_W-1:0]     chr_waddr, chr_raddr;
  logic [CHAR_W-1:0]     chr_rdata, rd_char;

  // Request classification straight from the incoming payload.
  assign printable = (char_code_i >= PRINT_LOW) && (char_code_i <= PRINT_HIGH);
  assign put_char  = (char_code_i == CH_TAB) ? CH_SPACE : (printable ? char_code_i : CH_SUBST);

  assign sts_o.is_read  = (req_type_i == REQ_READ);
  assign sts_o.is_cr    = (char_code_i == CH_CR);
  assign sts_o.is_lf    = (char_code_i == CH_LF);
  assign sts_o.is_tab   = (char_code_i == CH_TAB);
  assign sts_o.out_full = out_valid_q & ~out_ready_i;

  // A character that meets a full line opens a new one first.
  assign do_open = cmd_i.open_line | (cmd_i.put & (col_q == COL_W'(LINE_WIDTH)));

  always_comb begin
    oldest_n = oldest_q;
    held_n   = held_q;
    if (do_open) begin
      if (held_q < HELD_W'(LINES)) begin
        held_n = held_q + HELD_W'(1);
      end else if (oldest_q == SLOT_W'(LINES - 1)) begin
        oldest_n = '0;
      end else begin
        oldest_n = oldest_q + SLOT_W'(1);
      end
    end
  end

  // Newest slot after any open; the sum stays below twice the ring size.
  assign nsum     = (HELD_W+1)'(oldest_n) + (HELD_W+1)'(held_n) - (HELD_W+1)'(1);
  assign new_slot = (nsum >= (HELD_W+1)'(LINES)) ? SLOT_W'(nsum - (HELD_W+1)'(LINES))
                                                 : SLOT_W'(nsum);
  assign col_base = do_open ? '0 : col_q;

  assign len_we    = cmd_i.put | cmd_i.open_line;
  assign len_wdata = cmd_i.put ? (col_base + COL_W'(1)) : '0;
  assign chr_waddr = ADDR_W'(new_slot) * ADDR_W'(LINE_WIDTH) + ADDR_W'(col_base);

  always_comb begin
    oldest_d  = oldest_n;
    held_d    = held_n;
    col_d     = len_we ? len_wdata : col_q;
    len_vld_d = len_vld_q;
    if (len_we) begin
      len_vld_d[new_slot] = 1'b1;
    end
  end

  // Read side: logical line to ring slot.
  assign rsum      = (HELD_W+1)'(oldest_q) + (HELD_W+1)'(line_q);
  assign rd_slot   = (rsum >= (HELD_W+1)'(LINES)) ? SLOT_W'(rsum - (HELD_W+1)'(LINES))
                                                  : SLOT_W'(rsum);
  assign rd_hit    = (HELD_W+1)'(line_q) < (HELD_W+1)'(held_q);
  assign chr_raddr = ADDR_W'(rd_slot) * ADDR_W'(LINE_WIDTH) + ADDR_W'(rcol_q);

  assign rd_char = (hit_q && vld_q && (COL_W'(rcol_q) < len_rdata) &&
                    (COL_W'(rcol_q) < COL_W'(LINE_WIDTH))) ? chr_rdata : '0;

  tcsb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINES * LINE_WIDTH)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.put),
    .waddr_i (chr_waddr),
    .wdata_i (char_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (chr_raddr),
    .rdata_o (chr_rdata)
  );

  tcsb_ram #(
    .WIDTH (COL_W),
    .DEPTH (LINES)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (new_slot),
    .wdata_i (len_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_slot),
    .rdata_o (len_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      held_q      <= HELD_W'(1);
      col_q       <= '0;
      len_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      oldest_q  <= oldest_d;
      held_q    <= held_d;
      col_q     <= col_d;
      len_vld_q <= len_vld_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_read_q <= (req_type_i == REQ_READ);
      char_q    <= put_char;
      line_q    <= line_index_i;
      rcol_q    <= column_i;
    end
    if (cmd_i.rd_issue) begin
      hit_q <= rd_hit;
      vld_q <= len_vld_q[rd_slot];
    end
    if (cmd_i.load_out) begin
      read_char_q  <= is_read_q ? rd_char : '0;
      lines_held_q <= LH_W'(held_q);
      cursor_q     <= CC_W'(col_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_char_o     = read_char_q;
  assign lines_held_o    = lines_held_q;
  assign cursor_column_o = cursor_q;

endmodule

### hw/rtl/text_console_scrollback_buffer.sv
// Top level of the text console scrollback buffer: controller, datapath and channel wiring.
//
// Usage: requests arrive on req_i, one transaction per request. req_type selects an
// append of char_code to the open line or a read of line_index/column, where line 0
// is the oldest held line. Every request yields exactly one response transaction on
// rsp_o carrying read_char (0 for appends, past a line's end or past the lines held),
// lines_held and cursor_column as they stand after the request.
// After acceptance, a carriage return goes straight to the final state that loads the
// response; a printable byte first writes one character, a line feed first opens a line,
// a read first issues its RAM access, and a tab is expanded by the sequencer into four
// space writes to the character RAM. The request side is ready again in the cycle after
// the response is loaded; a read takes one registered RAM access.
// One request is handled at a time, but a finished response waits in the output
// register while the next request is taken and processed; if the receiver stalls,
// the block holds its next response in the final state until the register drains.
// Reset: one empty open line, cursor at column 0. Line lengths reset through per-line
// valid flops, so no clearing pass runs and requests are taken right after reset.
module text_console_scrollback_buffer
  import tcsb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tcsb_req_if.sink   req_i,
  tcsb_rsp_if.source rsp_o
);

  tcsb_cmd_t cmd;
  tcsb_sts_t sts;
  logic      in_ready;

  // The sequencer owns the request handshake; the datapath owns the response register.
  tcsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcsb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_i.req_type),
    .char_code_i     (req_i.char_code),
    .line_index_i    (req_i.line_index),
    .column_i        (req_i.column),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .read_char_o     (rsp_o.read_char),
    .lines_held_o    (rsp_o.lines_held),
    .cursor_column_o (rsp_o.cursor_column)
  );

  assign req_i.ready = in_ready;

endmodule

### hw/rtl/tcsb_checker.sv
// Port-level checker for the scrollback buffer and its bind to the top level.
`include "text_console_scrollback_buffer_assert.svh"

module tcsb_checker
  import tcsb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [CHAR_W-1:0] read_char_i,
  input logic [LH_W-1:0]   lines_held_i,
  input logic [CC_W-1:0]   cursor_column_i
);

  logic [CHAR_W+LH_W+CC_W-1:0] rsp_payload;
  assign rsp_payload = {read_char_i, lines_held_i, cursor_column_i};

  // At least the open line is held, never more than the ring size.
  `TCSB_ASSERT(a_lines_range, clk_i, rst_ni, rsp_valid_i |-> (lines_held_i != '0) && (lines_held_i <= LH_W'(LINES)), "lines_held out of range")

  // The cursor never passes the line width.
  `TCSB_ASSERT(a_cursor_range, clk_i, rst_ni, rsp_valid_i |-> (cursor_column_i <= CC_W'(LINE_WIDTH)), "cursor_column beyond line width")

  // A response does not rise straight after its request is accepted.
  `TCSB_ASSERT(a_min_latency, clk_i, rst_ni, (req_valid_i && req_ready_i) |=> !$rose(rsp_valid_i), "response appeared too early")

  `TCSB_ASSERT_HOLD(a_rsp_hold, clk_i, rst_ni, rsp_valid_i, rsp_ready_i, rsp_payload, "stalled response changed")

endmodule

bind text_console_scrollback_buffer tcsb_checker u_tcsb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .read_char_i     (rsp_o.read_char),
  .lines_held_i    (rsp_o.lines_held),
  .cursor_column_i (rsp_o.cursor_column)
);

### tb/tb_text_console_scrollback_buffer.sv
// Self-checking testbench for the text console scrollback buffer.
module tb_text_console_scrollback_buffer
  import tcsb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Stimulus volume, reporting and watchdog bounds.
  localparam int NUM_ITEMS      = 550;
  localparam int TAIL_ITEMS     = 60;
  localparam int BIG_LF_BURST   = 140;
  localparam int MAX_REPORTED   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  // One response transaction: the character read and the console status after the request.
  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [LH_W-1:0]   lines_held;
    logic [CC_W-1:0]   cursor_column;
  } console_status_t;

  // The scoreboard keeps its own copy of the scrollback ring. Every accepted request is
  // applied to that copy, and the resulting status is queued until the block answers.
  class console_scoreboard;
    logic [CHAR_W-1:0] text_store [LINES*LINE_WIDTH];
    logic [COL_W-1:0]  line_len [LINES];
    logic [SLOT_W-1:0] oldest_slot;
    logic [HELD_W-1:0] held_lines;
    logic [COL_W-1:0]  cursor;
    console_status_t   expected_q[$];
    int unsigned       mismatches;

    function new();
      foreach (text_store[i]) text_store[i] = '0;
      foreach (line_len[i]) line_len[i] = '0;
      oldest_slot = '0;
      held_lines  = 1;
      cursor      = '0;
      mismatches  = 0;
    endfunction

    // Length of a held line, addressed by its logical index.
    function logic [COL_W-1:0] length_of(int unsigned line);
      return line_len[(int'(oldest_slot) + line) % LINES];
    endfunction

    function void open_line();
      int slot;
      if (held_lines < LINES) begin
        slot = (int'(oldest_slot) + int'(held_lines)) % LINES;
        held_lines++;
      end else begin
        // The ring is full, so the oldest line is recycled as the new one.
        slot = int'(oldest_slot);
        oldest_slot = SLOT_W'((int'(oldest_slot) + 1) % LINES);
      end
      line_len[slot] = '0;
      cursor = '0;
    endfunction

    function void put_char(logic [CHAR_W-1:0] c);
      int slot;
      if (cursor >= LINE_WIDTH) open_line();
      slot = (int'(oldest_slot) + int'(held_lines) - 1) % LINES;
      text_store[slot*LINE_WIDTH + int'(cursor)] = c;
      cursor++;
      line_len[slot] = cursor;
    endfunction

    function logic [CHAR_W-1:0] fetch(logic [LINE_IDX_W-1:0] line, logic [COLUMN_W-1:0] col);
      int slot;
      if (line >= held_lines) return '0;
      if (col >= length_of(32'(line))) return '0;
      slot = (int'(oldest_slot) + int'(line)) % LINES;
      return text_store[slot*LINE_WIDTH + int'(col)];
    endfunction

    function void note_request(logic rtype, logic [CHAR_W-1:0] code,
                               logic [LINE_IDX_W-1:0] line, logic [COLUMN_W-1:0] col);
      console_status_t st;
      st.read_char = '0;
      if (rtype == REQ_APPEND) begin
        if (code == CH_CR) begin
        end else if (code == CH_LF) begin
          open_line();
        end else if (code == CH_TAB) begin
          for (int k = 0; k < TAB_SPACES; k++) put_char(CH_SPACE);
        end else if (code < PRINT_LOW || code > PRINT_HIGH) begin
          put_char(CH_SUBST);
        end else begin
          put_char(code);
        end
      end else begin
        st.read_char = fetch(line, col);
      end
      st.lines_held    = held_lines;
      st.cursor_column = cursor;
      expected_q.push_back(st);
    endfunction

    function void report(string field, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] seen);
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, seen);
    endfunction

    function void check_response(console_status_t got);
      console_status_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: response %h arrived with no request pending", $realtime, got);
        return;
      end
      want = expected_q.pop_front();
      if (want.read_char !== got.read_char) report("read_char", want.read_char, got.read_char);
      if (want.lines_held !== got.lines_held)
        report("lines_held", want.lines_held, got.lines_held);
      if (want.cursor_column !== got.cursor_column)
        report("cursor_column", CHAR_W'(want.cursor_column), CHAR_W'(got.cursor_column));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tcsb_req_if req_ch ();
  tcsb_rsp_if rsp_ch ();

  text_console_scrollback_buffer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  console_scoreboard sb = new();

  int unsigned sent_items = 0;
  int unsigned idle_pct   = 0;
  bit          quiet_tail = 1'b0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reset is held low at the start and then released for good.
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Both channels are sampled at the clock edge, before any flop of the block has updated,
  // so every transaction is seen with the payload that the block itself captured.
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready)
      sb.note_request(req_ch.req_type, req_ch.char_code, req_ch.line_index, req_ch.column);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(console_status_t'({rsp_ch.read_char, rsp_ch.lines_held,
                                           rsp_ch.cursor_column}));
  end

  // The watchdog counts cycles in which neither channel moves a transaction. Even the
  // slowest legal case, a tab behind a full sender gap and a full receiver stall, stays far
  // below the limit, so reaching it means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("tb_text_console_scrollback_buffer: errors");
      $finish;
    end
  end

  // The receiver alternates stretches of readiness with random stall bursts.
  // Once the run reaches its tail it stays ready.
  initial begin
    rsp_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // Presents one request and holds it until the block takes it. Valid stays high when the
  // next request follows at once, so it is never lowered and raised in the same step.
  // After the transaction the sender may idle for a random burst.
  task automatic send_request(input logic rtype, input logic [CHAR_W-1:0] code,
                              input logic [LINE_IDX_W-1:0] line,
                              input logic [COLUMN_W-1:0] col);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rtype;
    req_ch.char_code  <= code;
    req_ch.line_index <= line;
    req_ch.column     <= col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // A carriage return leaves the console untouched, so it does not count as work done.
    if (rtype == REQ_READ || code != CH_CR) sent_items++;
    if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic append_char(input logic [CHAR_W-1:0] code);
    send_request(REQ_APPEND, code, LINE_IDX_W'($urandom), COLUMN_W'($urandom));
  endtask

  task automatic read_at(input logic [LINE_IDX_W-1:0] line, input logic [COLUMN_W-1:0] col);
    send_request(REQ_READ, CHAR_W'($urandom), line, col);
  endtask

  // Stops sending and waits until every outstanding response has come back. The first
  // edge is waited out so that the last transaction has surely been noted.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Mostly printable text, with tabs, carriage returns and arbitrary bytes mixed in.
  function automatic logic [CHAR_W-1:0] random_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 78) return CHAR_W'($urandom_range(PRINT_LOW, PRINT_HIGH));
    if (r < 86) return CH_TAB;
    if (r < 90) return CH_CR;
    return CHAR_W'($urandom);
  endfunction

  // Most reads land on a stored character. The rest fall past the end of a line, past
  // the lines held, or anywhere at all.
  function automatic void choose_read(output logic [LINE_IDX_W-1:0] line,
                                      output logic [COLUMN_W-1:0] col);
    int unsigned r;
    int unsigned held;
    int unsigned len;
    r    = $urandom_range(0, 9);
    held = 32'(sb.held_lines);
    line = LINE_IDX_W'($urandom_range(0, held - 1));
    len  = 32'(sb.length_of(32'(line)));
    col  = (len > 0) ? COLUMN_W'($urandom_range(0, len - 1)) : '0;
    if (r == 8) begin
      line = (held < LINES) ? LINE_IDX_W'($urandom_range(held, LINES - 1))
                            : LINE_IDX_W'($urandom);
      col  = COLUMN_W'($urandom);
    end else if (r == 9) begin
      col = (len < LINE_WIDTH) ? COLUMN_W'(len) : COLUMN_W'($urandom);
    end
  endfunction

  initial begin
    logic [LINE_IDX_W-1:0] li;
    logic [COLUMN_W-1:0]   co;
    int unsigned           seg_len;
    bit                    big_done;

    big_done = 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_APPEND;
    req_ch.char_code  <= '0;
    req_ch.line_index <= '0;
    req_ch.column     <= '0;
    wait (rst_n);
    @(posedge clk);

    // Directed opening: the empty console, both ends of the printable range, control
    // bytes that become '?', the ignored carriage return, a tab, a line feed, and reads
    // on, past the end of, and beyond the held lines.
    idle_pct = 20;
    read_at(0, 0);
    read_at(LINE_IDX_W'(LINES - 1), COLUMN_W'(LINE_WIDTH - 1));
    append_char(PRINT_LOW);
    append_char(PRINT_HIGH);
    append_char(CHAR_W'(PRINT_LOW - 1));
    append_char(CHAR_W'(PRINT_HIGH + 1));
    append_char(8'h00);
    append_char(8'hFF);
    append_char(CH_CR);
    append_char(CH_TAB);
    read_at(0, 0);
    read_at(0, 1);
    read_at(0, 4);
    read_at(0, 9);
    read_at(0, 10);
    append_char(CH_LF);
    read_at(1, 0);
    read_at(0, 5);
    read_at(2, 0);
    append_char(8'h41);
    read_at(1, 0);

    // Let the pipeline empty completely before the random part starts.
    drain_responses();

    // Random part, built from segments: lines of text long enough to wrap, line feed
    // bursts, read bursts aimed at stored text, and pure noise. One long line feed burst
    // fills the ring so that the oldest lines start to be dropped.
    while (sent_items < NUM_ITEMS) begin
      if (sent_items >= NUM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (!big_done && sent_items >= 150) begin
        for (int i = 0; i < BIG_LF_BURST; i++) append_char(CH_LF);
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            seg_len = $urandom_range(5, 70);
            for (int i = 0; i < seg_len; i++) append_char(random_char());
          end
          4, 5: begin
            seg_len = $urandom_range(1, 6);
            for (int i = 0; i < seg_len; i++) append_char(CH_LF);
          end
          6, 7, 8: begin
            seg_len = $urandom_range(1, 12);
            for (int i = 0; i < seg_len; i++) begin
              choose_read(li, co);
              read_at(li, co);
            end
          end
          default: begin
            seg_len = $urandom_range(1, 6);
            for (int i = 0; i < seg_len; i++)
              send_request(1'($urandom), CHAR_W'($urandom), LINE_IDX_W'($urandom),
                           COLUMN_W'($urandom));
          end
        endcase
      end
      if (!quiet_tail && $urandom_range(0, 19) == 0) drain_responses();
    end

    // Wait for the last responses, then keep the clock running so that any response that
    // nobody asked for still shows.
    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_text_console_scrollback_buffer: clean");
    end else begin
      $display("tb_text_console_scrollback_buffer: errors");
    end
    $finish;
  end

endmodule

### text_console_scrollback_buffer.f
+incdir+hw/rtl
hw/rtl/tcsb_pkg.sv
hw/rtl/tcsb_req_if.sv
hw/rtl/tcsb_rsp_if.sv
hw/rtl/tcsb_ram.sv
hw/rtl/tcsb_ctrl.sv
hw/rtl/tcsb_dp.sv
hw/rtl/text_console_scrollback_buffer.sv
hw/rtl/tcsb_checker.sv
tb/tb_text_console_scrollback_buffer.sv
